>>> src/assert_macros.svh
// Assertion macros shared by the RTL. Each macro checks a property on the
// rising edge of aclk and is switched off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ERM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ERM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ERM_ASSERT_SAME(lbl, ante, cons)
`define ERM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> src/erm_pkg.sv
`default_nettype none
package erm_pkg;

    localparam int unsigned ANGLE_WIDTH_DEF   = 16;
    localparam int unsigned FRACTION_BITS_DEF = 14;
    localparam int unsigned CORDIC_STEPS      = 28;
    localparam int unsigned XY_W              = 34;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN_INIT = 34'sd652032874;

    localparam logic signed [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
        32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772, 32'sd166886,
        32'sd83443, 32'sd41722, 32'sd20861, 32'sd10430, 32'sd5215,
        32'sd2608, 32'sd1304, 32'sd652, 32'sd326, 32'sd163,
        32'sd81, 32'sd41, 32'sd20, 32'sd10, 32'sd5
    };

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
    } in_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } out_t;

    // One angle as it travels down the CORDIC chain.
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [31:0]     z;
        logic [1:0]             q;
    } lane_t;

    // Q30 product with rounding to nearest, ties upwards.
    function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd536870912;
        return p[61:30];
    endfunction

endpackage
`default_nettype wire

>>> src/erm_cordic_cell.sv
`default_nettype none
module erm_cordic_cell
    import erm_pkg::*;
#(
    parameter int unsigned STAGE = 0
) (
    input  wire logic  aclk,
    input  wire logic  en,
    input  wire lane_t lane_in,
    output lane_t      lane_out
);

    lane_t lane_reg, lane_next;
    logic signed [XY_W-1:0] dx, dy;

    // One micro-rotation by atan(2^-STAGE), direction chosen by the sign of z.
    always_comb begin
        dx = lane_in.y >>> STAGE;
        dy = lane_in.x >>> STAGE;
        lane_next.q = lane_in.q;
        if (!lane_in.z[31]) begin
            lane_next.x = lane_in.x - dx;
            lane_next.y = lane_in.y + dy;
            lane_next.z = lane_in.z - ATAN_TAB[STAGE];
        end else begin
            lane_next.x = lane_in.x + dx;
            lane_next.y = lane_in.y - dy;
            lane_next.z = lane_in.z + ATAN_TAB[STAGE];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule
`default_nettype wire

>>> src/erm_matrix.sv
`default_nettype none
module erm_matrix
    import erm_pkg::*;
#(
    parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic  aclk,
    input  wire logic  en,
    input  wire lane_t roll_lane,
    input  wire lane_t pitch_lane,
    input  wire lane_t yaw_lane,
    output out_t       mat_out
);

    localparam int unsigned SH = 30 - FRACTION_BITS;
    localparam logic signed [32:0] LIM = 33'sd1 <<< FRACTION_BITS;

    function automatic logic signed [31:0] clamp30(input logic signed [XY_W-1:0] v);
        if (v > 34'sd1073741824) begin
            return 32'sd1073741824;
        end else if (v < -34'sd1073741824) begin
            return -32'sd1073741824;
        end
        return v[31:0];
    endfunction

    function automatic logic [15:0] to_out(input logic signed [32:0] v);
        logic signed [33:0] r;
        if (SH > 0) begin
            r = (34'(v) + (34'sd1 <<< (SH - 1))) >>> SH;
        end else begin
            r = 34'(v);
        end
        if (r > 34'(LIM)) begin
            r = 34'(LIM);
        end else if (r < -34'(LIM)) begin
            r = -34'(LIM);
        end
        return r[15:0];
    endfunction

    // Stage 1: quadrant fold and clamp.
    logic signed [31:0] cr_reg, sr_reg, cp_reg, sp_reg, cy_reg, sy_reg;
    logic signed [31:0] cr_next, sr_next, cp_next, sp_next, cy_next, sy_next;

    function automatic logic signed [63:0] fold(input lane_t l);
        logic signed [XY_W-1:0] c, s;
        case (l.q)
            2'd0: begin c = l.x;  s = l.y;  end
            2'd1: begin c = -l.y; s = l.x;  end
            2'd2: begin c = -l.x; s = -l.y; end
            default: begin c = l.y; s = -l.x; end
        endcase
        return {clamp30(c), clamp30(s)};
    endfunction

    always_comb begin
        {cr_next, sr_next} = fold(roll_lane);
        {cp_next, sp_next} = fold(pitch_lane);
        {cy_next, sy_next} = fold(yaw_lane);
    end

    // Stage 2: first-level products.
    logic signed [31:0] cycp_reg, sycp_reg, cpsr_reg, cpcr_reg, cysp_reg, sysp_reg;
    logic signed [31:0] sycr_reg, sysr_reg, cycr_reg, cysr_reg;
    logic signed [31:0] sr2_reg, cr2_reg, sp2_reg;

    // Stage 3: triple products.
    logic signed [31:0] a01_reg, a02_reg, a11_reg, a12_reg;
    logic signed [31:0] b01_reg, b02_reg, b11_reg, b12_reg;
    logic signed [31:0] cycp3_reg, sycp3_reg, cpsr3_reg, cpcr3_reg, sp3_reg;

    out_t mat_reg, mat_next;

    always_comb begin
        mat_next.m00 = to_out(33'(cycp3_reg));
        mat_next.m01 = to_out(33'(a01_reg) - 33'(b01_reg));
        mat_next.m02 = to_out(33'(a02_reg) + 33'(b02_reg));
        mat_next.m10 = to_out(33'(sycp3_reg));
        mat_next.m11 = to_out(33'(a11_reg) + 33'(b11_reg));
        mat_next.m12 = to_out(33'(a12_reg) - 33'(b12_reg));
        mat_next.m20 = to_out(-33'(sp3_reg));
        mat_next.m21 = to_out(33'(cpsr3_reg));
        mat_next.m22 = to_out(33'(cpcr3_reg));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cr_reg <= cr_next;
            sr_reg <= sr_next;
            cp_reg <= cp_next;
            sp_reg <= sp_next;
            cy_reg <= cy_next;
            sy_reg <= sy_next;

            cycp_reg <= mul30(cy_reg, cp_reg);
            sycp_reg <= mul30(sy_reg, cp_reg);
            cpsr_reg <= mul30(cp_reg, sr_reg);
            cpcr_reg <= mul30(cp_reg, cr_reg);
            cysp_reg <= mul30(cy_reg, sp_reg);
            sysp_reg <= mul30(sy_reg, sp_reg);
            sycr_reg <= mul30(sy_reg, cr_reg);
            sysr_reg <= mul30(sy_reg, sr_reg);
            cycr_reg <= mul30(cy_reg, cr_reg);
            cysr_reg <= mul30(cy_reg, sr_reg);
            sr2_reg  <= sr_reg;
            cr2_reg  <= cr_reg;
            sp2_reg  <= sp_reg;

            a01_reg   <= mul30(cysp_reg, sr2_reg);
            a02_reg   <= mul30(cysp_reg, cr2_reg);
            a11_reg   <= mul30(sysp_reg, sr2_reg);
            a12_reg   <= mul30(sysp_reg, cr2_reg);
            b01_reg   <= sycr_reg;
            b02_reg   <= sysr_reg;
            b11_reg   <= cycr_reg;
            b12_reg   <= cysr_reg;
            cycp3_reg <= cycp_reg;
            sycp3_reg <= sycp_reg;
            cpsr3_reg <= cpsr_reg;
            cpcr3_reg <= cpcr_reg;
            sp3_reg   <= sp2_reg;

            mat_reg <= mat_next;
        end
    end

    assign mat_out = mat_reg;

endmodule
`default_nettype wire

>>> src/euler_to_rotation_matrix.sv
`default_nettype none
// Roll, pitch and yaw (half-turn fractions, full scale is pi) in; the nine
// elements of R = Rz(yaw) * Ry(pitch) * Rx(roll) in signed fixed point with
// FRACTION_BITS fraction bits out, rounded and saturated to plus or minus one.
// One angle triple is taken in every clock cycle while input ready is high;
// on its way to the output it passes 34 registers, the first of which loads
// at the input transfer itself: a quadrant-reduction register, a chain of 28
// CORDIC cells (one per micro-rotation, three angles side by side), four
// matrix stages for quadrant fold, products, sums and rounding, and the
// output register. The pipeline only halts when a result is held at the
// output and a second one is parked in the skid register behind it; input
// ready then drops until the downstream side takes a transfer.
module euler_to_rotation_matrix
    import erm_pkg::*;
#(
    parameter int unsigned ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
    parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

`include "assert_macros.svh"

    // Quadrant register, CORDIC cells and the four matrix stages.
    localparam int unsigned LAT = 1 + CORDIC_STEPS + 4;

    logic en;
    logic [LAT-1:0] pipe_valid_reg, pipe_valid_next;
    logic skid_valid_reg, out_valid_reg;
    out_t skid_reg, out_reg, tail_data;

    // The pipeline runs whenever the skid register is empty.
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // Reduce an angle to a quadrant and a residual in [-pi/2, 0).
    function automatic lane_t reduce(input logic [15:0] raw);
        logic [31:0] phase, shifted, resid;
        lane_t l;
        phase   = 32'({16'd0, raw}) << (32 - ANGLE_WIDTH);
        shifted = phase + 32'h4000_0000;
        l.q     = shifted[31:30];
        resid   = phase - {l.q, 30'd0};
        l.x     = CORDIC_GAIN_INIT;
        l.y     = '0;
        l.z     = resid;
        return l;
    endfunction

    lane_t chain [3][CORDIC_STEPS+1];
    lane_t entry_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            entry_reg[0] <= reduce(s_data.roll_angle);
            entry_reg[1] <= reduce(s_data.pitch_angle);
            entry_reg[2] <= reduce(s_data.yaw_angle);
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign chain[l][0] = entry_reg[l];
        for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
            erm_cordic_cell #(
                .STAGE(i)
            ) u_cell (
                .aclk    (aclk),
                .en      (en),
                .lane_in (chain[l][i]),
                .lane_out(chain[l][i+1])
            );
        end
    end

    erm_matrix #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_matrix (
        .aclk      (aclk),
        .en        (en),
        .roll_lane (chain[0][CORDIC_STEPS]),
        .pitch_lane(chain[1][CORDIC_STEPS]),
        .yaw_lane  (chain[2][CORDIC_STEPS]),
        .mat_out   (tail_data)
    );

    // Valid bits travel alongside the data.
    assign pipe_valid_next = {pipe_valid_reg[LAT-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_valid_reg <= '0;
        end else if (en) begin
            pipe_valid_reg <= pipe_valid_next;
        end
    end

    // Output register with a single skid entry behind it. When a result is
    // stalled at the output, the next one to leave the pipeline is parked in
    // the skid register, which in turn halts the pipeline.
    logic take;
    assign take = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || take) begin
            out_reg       <= tail_data;
            out_valid_reg <= pipe_valid_reg[LAT-1];
        end else if (pipe_valid_reg[LAT-1]) begin
            skid_reg       <= tail_data;
            skid_valid_reg <= 1'b1;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // A parked result always has one ahead of it at the output.
    `ERM_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    // A held output with a full tail must fill the skid register.
    `ERM_ASSERT_NEXT(a_skid_fill, en && out_valid_reg && !m_ready && pipe_valid_reg[LAT-1],
                     skid_valid_reg)
    // While halted, the pipeline's valid bits do not move.
    `ERM_ASSERT_NEXT(a_halt_holds, !en, $stable(pipe_valid_reg))

endmodule
`default_nettype wire
